// ----- design/msc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo slew controller package
// Shared widths, reset values, reciprocal constants, codes and types.
// ----------------------------------------------------------------------------
package msc_pkg;

	localparam int NUM_SERVOS_DEF = 8;

	localparam int MDEG_W     = 18;
	localparam int SPD_W      = 10;
	localparam int AGE_W      = 16;
	localparam int EL_W       = 10;
	localparam int ANG_W      = 11;
	localparam int PULSE_W    = 12;
	localparam int CHAN_W     = 3;
	localparam int DEG_W      = 8;
	localparam int STEP_W     = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Shared multiplier operand and product widths.
	localparam int MUL_W       = 21;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int RECIP_SHIFT = 28;

	localparam logic [MDEG_W-1:0] RESET_MDEG   = 18'd90000;
	localparam logic [MDEG_W-1:0] MAX_MDEG     = 18'd180000;
	localparam logic [SPD_W-1:0]  RESET_SPEED  = 10'd60;
	localparam logic [DEG_W-1:0]  MAX_DEG      = 8'd180;
	localparam logic [MDEG_W-1:0] MDEG_PER_DEG = 18'd1000;
	localparam logic [AGE_W-1:0]  AGE_MAX      = 16'hFFFF;

	// Scaled reciprocals, exact for the operand ranges used here.
	localparam logic [MUL_W-1:0] RECIP_1000 = 21'd268436;
	localparam logic [MUL_W-1:0] RECIP_180  = 21'd1491309;

	localparam logic [AGE_W-1:0]   TIMEOUT_RST   = 16'd200;
	localparam logic [PULSE_W-1:0] PULSE_MIN_RST = 12'd1000;
	localparam logic [PULSE_W-1:0] PULSE_MAX_RST = 12'd2000;

	typedef enum logic {
		CMD_SET  = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIMEOUT   = 2'd0,
		CFG_PULSE_MIN = 2'd1,
		CFG_PULSE_MAX = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_STEP,
		SQ_MOVE,
		SQ_SCALE,
		SQ_DIV,
		SQ_EMIT
	} seq_state_t;

	typedef struct packed {
		logic              en;
		logic [MDEG_W-1:0] tgt;
		logic [SPD_W-1:0]  spd;
	} chan_set_t;

	typedef struct packed {
		logic              en;
		logic [MDEG_W-1:0] cur;
		logic [MDEG_W-1:0] tgt;
	} chan_upd_t;

endpackage

// ----- design/msc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo slew controller channel interfaces
// Request, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface msc_req_if import msc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    command;
	logic [CHAN_W-1:0]       servo_id;
	logic signed [ANG_W-1:0] angle_deg;
	logic signed [ANG_W-1:0] speed_dps;
	logic [EL_W-1:0]         elapsed_ms;

	modport source(output valid, command, servo_id, angle_deg, speed_dps, elapsed_ms,
		input ready);
	modport sink(input valid, command, servo_id, angle_deg, speed_dps, elapsed_ms,
		output ready);
endinterface

interface msc_rsp_if import msc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CHAN_W-1:0]  channel;
	logic [PULSE_W-1:0] pulse_us;
	logic               last;

	modport source(output valid, channel, pulse_us, last, input ready);
	modport sink(input valid, channel, pulse_us, last, output ready);
endinterface

interface msc_cfg_if import msc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- design/multi_servo_slew_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-servo slew controller
// Slew-rate limited position control for a bank of hobby servos.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on req. A set-target item (command 0) loads the angle, clamped
// to 0..180 degrees, and the speed, at least 1 deg/s, of one channel and
// clears the command age; it gives no result. A channel
// number at or above NUM_SERVOS is ignored. A tick item (command 1) ages the
// last command by elapsed_ms, freezes every target once the age passes
// timeout_ms, moves each channel toward its target and then sends one result
// per channel on rsp, in channel order, with last set on the final one.
// A tick runs the channels one at a time through a single shared multiplier,
// each in the steps step, move, degrees, scale and divide by 180 before its
// result is emitted. req.ready is low for the whole run. A stalled receiver
// holds the result register and the sequencer waits on it.
// Registers on cfg (index 0 timeout_ms, 1 pulse_min_us, 2 pulse_max_us) are
// written whenever cfg.valid is high and should only change while the block is idle.
// Reset puts every channel at 90 degrees, 60 deg/s, and restores the register
// defaults; it takes effect at once.
// ----------------------------------------------------------------------------
module multi_servo_slew_controller import msc_pkg::*; #(
	parameter int NUM_SERVOS = NUM_SERVOS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	msc_req_if.sink   req,
	msc_rsp_if.source rsp,
	msc_cfg_if.sink   cfg
);

	localparam int IDX_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;

	// Configuration registers.
	logic [AGE_W-1:0]   timeout_q;
	logic [PULSE_W-1:0] pulse_min_q;
	logic [PULSE_W-1:0] pulse_max_q;

	// Channel store and multiplier hookup.
	chan_set_t          set;
	chan_upd_t          upd;
	logic [IDX_W-1:0]   wr_idx;
	logic [IDX_W-1:0]   rd_idx;
	logic [MDEG_W-1:0]  rd_cur;
	logic [MDEG_W-1:0]  rd_tgt;
	logic [SPD_W-1:0]   rd_spd;
	logic               mul_en;
	logic [MUL_W-1:0]   mul_a;
	logic [MUL_W-1:0]   mul_b;
	logic [PROD_W-1:0]  prod_q;

	// The register port never stalls. Writes to an index that names no
	// register are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= TIMEOUT_RST;
			pulse_min_q <= PULSE_MIN_RST;
			pulse_max_q <= PULSE_MAX_RST;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				CFG_TIMEOUT:   timeout_q   <= cfg.data[AGE_W-1:0];
				CFG_PULSE_MIN: pulse_min_q <= cfg.data[PULSE_W-1:0];
				CFG_PULSE_MAX: pulse_max_q <= cfg.data[PULSE_W-1:0];
				default: begin
					timeout_q <= timeout_q;
				end
			endcase
		end
	end

	msc_seq #(
		.NUM_SERVOS(NUM_SERVOS),
		.IDX_W     (IDX_W)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.timeout_ms  (timeout_q),
		.pulse_min_us(pulse_min_q),
		.pulse_max_us(pulse_max_q),
		.set         (set),
		.upd         (upd),
		.wr_idx      (wr_idx),
		.rd_idx      (rd_idx),
		.rd_cur      (rd_cur),
		.rd_tgt      (rd_tgt),
		.rd_spd      (rd_spd),
		.mul_en      (mul_en),
		.mul_a       (mul_a),
		.mul_b       (mul_b),
		.prod_q      (prod_q)
	);

	msc_chan_regs #(
		.NUM_SERVOS(NUM_SERVOS),
		.IDX_W     (IDX_W)
	) u_chan_regs (
		.clk   (clk),
		.arst_n(arst_n),
		.set   (set),
		.upd   (upd),
		.wr_idx(wr_idx),
		.rd_idx(rd_idx),
		.rd_cur(rd_cur),
		.rd_tgt(rd_tgt),
		.rd_spd(rd_spd)
	);

	msc_mul u_mul (
		.clk   (clk),
		.en    (mul_en),
		.a     (mul_a),
		.b     (mul_b),
		.prod_q(prod_q)
	);

endmodule

// ----- design/msc_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned multiplier with a registered product, reused for every step.
// ----------------------------------------------------------------------------
module msc_mul import msc_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [MUL_W-1:0]  a,
	input  logic [MUL_W-1:0]  b,
	output logic [PROD_W-1:0] prod_q
);

	// The product is held while en is low.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PROD_W'(a) * PROD_W'(b);
		end
	end

endmodule

// ----- design/msc_chan_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel state registers
// Current angle, target angle and slew speed of every servo channel.
// ----------------------------------------------------------------------------
module msc_chan_regs import msc_pkg::*; #(
	parameter int NUM_SERVOS = NUM_SERVOS_DEF,
	parameter int IDX_W      = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  chan_set_t         set,
	input  chan_upd_t         upd,
	input  logic [IDX_W-1:0]  wr_idx,
	input  logic [IDX_W-1:0]  rd_idx,
	output logic [MDEG_W-1:0] rd_cur,
	output logic [MDEG_W-1:0] rd_tgt,
	output logic [SPD_W-1:0]  rd_spd
);

	logic [MDEG_W-1:0] cur_q [NUM_SERVOS];
	logic [MDEG_W-1:0] tgt_q [NUM_SERVOS];
	logic [SPD_W-1:0]  spd_q [NUM_SERVOS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SERVOS; i++) begin
				cur_q[i] <= RESET_MDEG;
				tgt_q[i] <= RESET_MDEG;
				spd_q[i] <= RESET_SPEED;
			end
		end else if (set.en) begin
			tgt_q[wr_idx] <= set.tgt;
			spd_q[wr_idx] <= set.spd;
		end else if (upd.en) begin
			cur_q[wr_idx] <= upd.cur;
			tgt_q[wr_idx] <= upd.tgt;
		end
	end

	assign rd_cur = cur_q[rd_idx];
	assign rd_tgt = tgt_q[rd_idx];
	assign rd_spd = spd_q[rd_idx];

	// A new target and a position update never land in the same cycle.
	a_no_dual_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(set.en && upd.en))
		else $error("set and update write in the same cycle");

	a_upd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		upd.en |-> (upd.cur <= MAX_MDEG && upd.tgt <= MAX_MDEG))
		else $error("position update out of range");

	a_set_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		set.en |-> (set.tgt <= MAX_MDEG && set.spd != '0))
		else $error("new target or speed out of range");

endmodule

// ----- design/msc_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo slew sequencer
// Takes items, keeps the command age and walks the channels on a tick,
// driving the shared multiplier and the result register.
// ----------------------------------------------------------------------------
module msc_seq import msc_pkg::*; #(
	parameter int NUM_SERVOS = NUM_SERVOS_DEF,
	parameter int IDX_W      = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	msc_req_if.sink            req,
	msc_rsp_if.source          rsp,
	input  logic [AGE_W-1:0]   timeout_ms,
	input  logic [PULSE_W-1:0] pulse_min_us,
	input  logic [PULSE_W-1:0] pulse_max_us,
	output chan_set_t          set,
	output chan_upd_t          upd,
	output logic [IDX_W-1:0]   wr_idx,
	output logic [IDX_W-1:0]   rd_idx,
	input  logic [MDEG_W-1:0]  rd_cur,
	input  logic [MDEG_W-1:0]  rd_tgt,
	input  logic [SPD_W-1:0]   rd_spd,
	output logic               mul_en,
	output logic [MUL_W-1:0]   mul_a,
	output logic [MUL_W-1:0]   mul_b,
	input  logic [PROD_W-1:0]  prod_q
);

	seq_state_t state_q, state_d;

	logic [IDX_W-1:0]   idx_q;
	logic [EL_W-1:0]    el_q;
	logic               freeze_q;
	logic [AGE_W-1:0]   age_q;
	logic               out_valid_q;
	logic [CHAN_W-1:0]  out_chan_q;
	logic [PULSE_W-1:0] out_pulse_q;
	logic               out_last_q;

	logic               accept;
	logic               tick_acc;
	logic               set_acc;
	logic               id_ok;
	logic [IDX_W+CHAN_W-1:0] id_ext;
	logic [IDX_W+CHAN_W-1:0] chan_ext;
	logic [AGE_W:0]     age_sum;
	logic [AGE_W-1:0]   age_new;
	logic               last_ch;
	logic               emit_ok;
	logic               emit;

	logic [DEG_W-1:0]   ang_clamp;
	logic [SPD_W-1:0]   spd_clamp;

	logic [MDEG_W-1:0]  tgt_eff;
	logic [STEP_W-1:0]  step;
	logic [MDEG_W-1:0]  diff;
	logic               moving_up;
	logic [MDEG_W-1:0]  new_cur;

	logic [PROD_W-RECIP_SHIFT-1:0] deg_full;
	logic [DEG_W-1:0]   deg;
	logic signed [PULSE_W:0] span;
	logic               span_neg;
	logic [PULSE_W-1:0] span_mag;
	logic [PULSE_W-1:0] quot;
	logic [PULSE_W-1:0] pulse;

	// ---------------------------------------------------------------- intake
	assign accept   = req.valid && req.ready;
	assign tick_acc = accept && (req.command == CMD_TICK);
	assign id_ok    = int'(req.servo_id) < NUM_SERVOS;
	assign set_acc  = accept && (req.command == CMD_SET) && id_ok;
	assign id_ext   = {IDX_W'(0), req.servo_id};

	always_comb begin
		if (req.angle_deg < 0) begin
			ang_clamp = '0;
		end else if (req.angle_deg > $signed({3'b000, MAX_DEG})) begin
			ang_clamp = MAX_DEG;
		end else begin
			ang_clamp = req.angle_deg[DEG_W-1:0];
		end
		if (req.speed_dps < 1) begin
			spd_clamp = SPD_W'(1);
		end else begin
			spd_clamp = req.speed_dps[SPD_W-1:0];
		end
	end

	assign age_sum = {1'b0, age_q} + (AGE_W+1)'(req.elapsed_ms);
	assign age_new = age_sum[AGE_W] ? AGE_MAX : age_sum[AGE_W-1:0];

	// ------------------------------------------------------------ datapath
	// A frozen target equals the current angle, so the channel stays put.
	assign tgt_eff   = freeze_q ? rd_cur : rd_tgt;
	assign step      = prod_q[STEP_W-1:0];
	assign moving_up = tgt_eff >= rd_cur;
	assign diff      = moving_up ? (tgt_eff - rd_cur) : (rd_cur - tgt_eff);

	always_comb begin
		if ({(STEP_W-MDEG_W)'(0), diff} <= step) begin
			new_cur = tgt_eff;
		end else if (moving_up) begin
			new_cur = rd_cur + step[MDEG_W-1:0];
		end else begin
			new_cur = rd_cur - step[MDEG_W-1:0];
		end
	end

	assign deg_full = prod_q[PROD_W-1:RECIP_SHIFT];
	assign deg      = (deg_full > (PROD_W-RECIP_SHIFT)'(MAX_DEG)) ? MAX_DEG
		: deg_full[DEG_W-1:0];

	assign span     = $signed({1'b0, pulse_max_us}) - $signed({1'b0, pulse_min_us});
	assign span_neg = span[PULSE_W];
	assign span_mag = span_neg ? PULSE_W'(-span) : span[PULSE_W-1:0];

	assign quot  = prod_q[RECIP_SHIFT +: PULSE_W];
	assign pulse = pulse_min_us + (span_neg ? (~quot + PULSE_W'(1)) : quot);

	assign last_ch  = idx_q == IDX_W'(NUM_SERVOS - 1);
	assign chan_ext = {CHAN_W'(0), idx_q};
	assign emit_ok  = !out_valid_q || rsp.ready;
	assign rd_idx   = idx_q;

	// -------------------------------------------------------- state machine
	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE: begin
				if (tick_acc) begin
					state_d = SQ_STEP;
				end
			end
			SQ_STEP:  state_d = SQ_MOVE;
			SQ_MOVE:  state_d = SQ_SCALE;
			SQ_SCALE: state_d = SQ_DIV;
			SQ_DIV:   state_d = SQ_EMIT;
			SQ_EMIT: begin
				if (emit_ok) begin
					state_d = last_ch ? SQ_IDLE : SQ_STEP;
				end
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		mul_en    = 1'b1;
		mul_a     = '0;
		mul_b     = '0;
		set       = '0;
		upd       = '0;
		emit      = 1'b0;
		wr_idx    = idx_q;
		case (state_q)
			SQ_IDLE: begin
				req.ready = 1'b1;
				wr_idx    = id_ext[IDX_W-1:0];
				set.en    = set_acc;
				set.tgt   = MDEG_W'(ang_clamp) * MDEG_PER_DEG;
				set.spd   = spd_clamp;
			end
			SQ_STEP: begin
				mul_a = MUL_W'(rd_spd);
				mul_b = MUL_W'(el_q);
			end
			SQ_MOVE: begin
				upd.en  = 1'b1;
				upd.cur = new_cur;
				upd.tgt = tgt_eff;
				mul_a   = MUL_W'(new_cur);
				mul_b   = RECIP_1000;
			end
			SQ_SCALE: begin
				mul_a = MUL_W'(deg);
				mul_b = MUL_W'(span_mag);
			end
			SQ_DIV: begin
				mul_a = prod_q[MUL_W-1:0];
				mul_b = RECIP_180;
			end
			SQ_EMIT: begin
				// The quotient must survive a stalled receiver.
				mul_en = 1'b0;
				emit   = emit_ok;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	// ------------------------------------------------------------ registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SQ_IDLE;
			idx_q       <= '0;
			el_q        <= '0;
			freeze_q    <= 1'b0;
			age_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (set_acc) begin
				age_q <= '0;
			end else if (tick_acc) begin
				age_q    <= age_new;
				el_q     <= req.elapsed_ms;
				freeze_q <= age_new > timeout_ms;
				idx_q    <= '0;
			end else if (emit) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_chan_q  <= chan_ext[CHAN_W-1:0];
			out_pulse_q <= pulse;
			out_last_q  <= last_ch;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.channel  = out_chan_q;
	assign rsp.pulse_us = out_pulse_q;
	assign rsp.last     = out_last_q;

	// ----------------------------------------------------------- assertions
	a_busy_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> !req.ready)
		else $error("item taken while a tick is in progress");

	a_pulse_between_limits: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> ((pulse >= pulse_min_us && pulse <= pulse_max_us)
			|| (pulse >= pulse_max_us && pulse <= pulse_min_us)))
		else $error("pulse width outside the configured limits");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_ch) |=> (state_q == SQ_IDLE))
		else $error("sequencer did not return to idle after the last channel");

endmodule
